// File: rtl/rns_pkg.sv
// rns_pkg: shared types and constants of the residual norm block
// transaction structs for commands and results, opcodes, register indexes
// no dependencies
package rns_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_MATRIX   = 2'd0,
        OP_LOAD_RHS      = 2'd1,
        OP_LOAD_SOLUTION = 2'd2,
        OP_START         = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SIZE       = 2'd0,
        CFG_PART_INDEX = 2'd1,
        CFG_PART_COUNT = 2'd2
    } cfg_index_t;

    localparam int VALUE_W = 32;
    localparam int CFG_W   = 7;
    localparam int SUM_W   = 63;

    localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [15:0]      ROUND_BIAS = 16'h8000;

    typedef struct packed {
        op_t                       op;
        logic [5:0]                row;
        logic [5:0]                col;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [SUM_W-1:0] residual_sum;
        logic             saturated;
    } result_t;

endpackage

// File: rtl/rns_ram.sv
// rns_ram: generic single write port, single read port ram
// read data is registered; contents are undefined until written
// no dependencies
module rns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/residual_norm_squared.sv
// residual_norm_squared: top level, squared residual norm over a row slice
// uses rns_pkg for types and constants, rns_ram for the three stores
//
// Load commands (matrix, rhs, solution element) are written straight to
// their stores and busy stays low. A start command raises busy until the
// result is out: first the slice bounds are found by a bit-serial divider
// in two passes, then each row of the slice is processed in turn. Each row
// goes through the single matrix ram read port and the one shared 32x32
// multiplier, which does one multiply-accumulate per cycle and also
// squares each residual. Done is high for exactly one cycle with the result
// on result and cannot be held off; a new command may be given in the
// cycle that done is high. Configuration writes are taken at any time but
// must only be made while busy is low.
module residual_norm_squared #(
    parameter int MAX_ORDER = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  rns_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      done,
    output rns_pkg::result_t          result,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [rns_pkg::CFG_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_ORDER);
    localparam int MAT_D  = MAX_ORDER * MAX_ORDER;
    localparam int MAT_AW = $clog2(MAT_D);
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int DVD_W  = CNT_W + 7;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int ACC_W  = 64 + CNT_W;
    localparam int RES_W  = ACC_W - 15;
    localparam int WIDE_W = IDX_W + 6;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV    = 8'b0000_0010,
        S_ROW    = 8'b0000_0100,
        S_MAC    = 8'b0000_1000,
        S_ROUND  = 8'b0001_0000,
        S_RESID  = 8'b0010_0000,
        S_SQUARE = 8'b0100_0000,
        S_ACCUM  = 8'b1000_0000
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [6:0]          size_reg;
    logic [5:0]          pidx_reg;
    logic [6:0]          pcount_reg;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [CNT_W-1:0]    col_reg, col_next;
    logic                rd_v_reg, rd_v_next;
    logic                prod_v_reg, prod_v_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                dpass_reg, dpass_next;

    // datapath registers
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    begin_reg, begin_next;
    logic [CNT_W-1:0]    end_reg, end_next;
    logic [6:0]          divisor_reg, divisor_next;
    logic [6:0]          rem_reg, rem_next;
    logic [DVD_W-1:0]    quo_reg, quo_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [63:0]         prod_reg, prod_next;
    logic [31:0]         resid_reg, resid_next;
    logic [rns_pkg::SUM_W-1:0] total_reg, total_next;
    logic                sat_reg, sat_next;
    rns_pkg::result_t    result_reg, result_next;

    // command decode and store writes
    logic                accept;
    logic [WIDE_W-1:0]   row_wide, col_wide;
    logic                row_ok, col_ok;
    logic [IDX_W-1:0]    ld_row, ld_col;
    logic                mat_we, rhs_we, sol_we;
    logic [MAT_AW-1:0]   mat_waddr, mat_raddr;
    logic [IDX_W-1:0]    run_row, run_col;
    logic [31:0]         mat_rdata, rhs_rdata, sol_rdata;

    // shared units
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic [ACC_W-1:0]    add_b, add_sum;
    logic [7:0]          rem_sh;
    logic                div_ge;
    logic [7:0]          rem_sub;
    logic [DVD_W-1:0]    quo_step;
    logic [CNT_W-1:0]    quo_clamp;
    logic [CNT_W-1:0]    n_cmd;
    logic [6:0]          pidx_p1;
    logic [RES_W-1:0]    diff;
    logic                diff_hi, diff_lo;
    logic [63:0]         sum_ext;

    assign accept   = start && !busy;
    assign row_wide = {{IDX_W{1'b0}}, cmd.row};
    assign col_wide = {{IDX_W{1'b0}}, cmd.col};
    assign row_ok   = row_wide < WIDE_W'(MAX_ORDER);
    assign col_ok   = col_wide < WIDE_W'(MAX_ORDER);
    assign ld_row   = row_wide[IDX_W-1:0];
    assign ld_col   = col_wide[IDX_W-1:0];

    assign mat_we = accept && cmd.op == rns_pkg::OP_LOAD_MATRIX && row_ok && col_ok;
    assign rhs_we = accept && cmd.op == rns_pkg::OP_LOAD_RHS && row_ok;
    assign sol_we = accept && cmd.op == rns_pkg::OP_LOAD_SOLUTION && col_ok;

    assign mat_waddr = MAT_AW'(ld_row) * MAT_AW'(MAX_ORDER) + MAT_AW'(ld_col);
    assign run_row   = row_reg[IDX_W-1:0];
    assign run_col   = col_reg[IDX_W-1:0];
    assign mat_raddr = MAT_AW'(run_row) * MAT_AW'(MAX_ORDER) + MAT_AW'(run_col);

    rns_ram #(
        .WIDTH (32),
        .DEPTH (MAT_D)
    ) u_matrix_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (cmd.value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    rns_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ORDER)
    ) u_rhs_ram (
        .clk   (clk),
        .we    (rhs_we),
        .waddr (ld_row),
        .wdata (cmd.value),
        .raddr (run_row),
        .rdata (rhs_rdata)
    );

    rns_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ORDER)
    ) u_solution_ram (
        .clk   (clk),
        .we    (sol_we),
        .waddr (ld_col),
        .wdata (cmd.value),
        .raddr (run_col),
        .rdata (sol_rdata)
    );

    // shared multiplier: dot product terms, then the residual square
    assign mul_a = (state_reg == S_SQUARE) ? $signed(resid_reg) : $signed(mat_rdata);
    assign mul_b = (state_reg == S_SQUARE) ? $signed(resid_reg) : $signed(sol_rdata);
    assign mul_p = mul_a * mul_b;

    // shared accumulator adder: product terms, then the rounding bias
    assign add_b   = (state_reg == S_ROUND) ? ACC_W'(rns_pkg::ROUND_BIAS)
                                            : {{CNT_W{prod_reg[63]}}, prod_reg};
    assign add_sum = acc_reg + add_b;

    // restoring divider step
    assign rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
    assign div_ge   = rem_sh >= {1'b0, divisor_reg};
    assign rem_sub  = div_ge ? rem_sh - {1'b0, divisor_reg} : rem_sh;
    assign quo_step = {quo_reg[DVD_W-2:0], div_ge};
    assign quo_clamp = (quo_step > DVD_W'(n_reg)) ? n_reg : quo_step[CNT_W-1:0];

    assign n_cmd   = (32'(size_reg) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(size_reg);
    assign pidx_p1 = {1'b0, pidx_reg} + 7'd1;

    // residual rounded to q16.16 and clipped
    assign diff    = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:16]}
                   - {{(RES_W-32){rhs_rdata[31]}}, rhs_rdata};
    assign diff_hi = !diff[RES_W-1] && (|diff[RES_W-2:31]);
    assign diff_lo = diff[RES_W-1] && !(&diff[RES_W-2:31]);

    assign sum_ext = {1'b0, total_reg} + {1'b0, prod_reg[62:0]};

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        row_next     = row_reg;
        col_next     = col_reg;
        rd_v_next    = 1'b0;
        prod_v_next  = rd_v_reg;
        dcnt_next    = dcnt_reg;
        dpass_next   = dpass_reg;
        n_next       = n_reg;
        begin_next   = begin_reg;
        end_next     = end_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        acc_next     = acc_reg;
        prod_next    = mul_p;
        resid_next   = resid_reg;
        total_next   = total_reg;
        sat_next     = sat_reg;
        result_next  = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.op == rns_pkg::OP_START)
                begin
                    n_next       = n_cmd;
                    divisor_next = (pcount_reg == 7'd0) ? 7'd1 : pcount_reg;
                    rem_next     = 7'd0;
                    quo_next     = DVD_W'(n_cmd) * DVD_W'(pidx_reg);
                    dcnt_next    = '0;
                    dpass_next   = 1'b0;
                    total_next   = '0;
                    sat_next     = 1'b0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = rem_sub[6:0];
                quo_next  = quo_step;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DVD_W - 1))
                begin
                    dcnt_next = '0;
                    if (!dpass_reg)
                    begin
                        begin_next = quo_clamp;
                        dpass_next = 1'b1;
                        rem_next   = 7'd0;
                        quo_next   = DVD_W'(n_reg) * DVD_W'(pidx_p1);
                    end
                    else
                    begin
                        end_next   = quo_clamp;
                        row_next   = begin_reg;
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW:
            begin
                if (row_reg >= end_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{residual_sum: total_reg, saturated: sat_reg};
                    state_next  = S_IDLE;
                end
                else
                begin
                    acc_next   = '0;
                    col_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (col_reg < n_reg)
                begin
                    rd_v_next = 1'b1;
                    col_next  = col_reg + 1'b1;
                end
                if (prod_v_reg)
                begin
                    acc_next = add_sum;
                end
                if (col_reg == n_reg && !rd_v_reg && !prod_v_reg)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                acc_next   = add_sum;
                state_next = S_RESID;
            end
            S_RESID:
            begin
                if (diff_hi)
                begin
                    resid_next = 32'h7FFF_FFFF;
                    sat_next   = 1'b1;
                end
                else if (diff_lo)
                begin
                    resid_next = 32'h8000_0000;
                    sat_next   = 1'b1;
                end
                else
                begin
                    resid_next = diff[31:0];
                end
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (sum_ext[63])
                begin
                    total_next = rns_pkg::SUM_MAX;
                    sat_next   = 1'b1;
                end
                else
                begin
                    total_next = sum_ext[62:0];
                end
                row_next   = row_reg + 1'b1;
                state_next = S_ROW;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            dcnt_reg   <= '0;
            dpass_reg  <= 1'b0;
            size_reg   <= 7'd1;
            pidx_reg   <= 6'd0;
            pcount_reg <= 7'd1;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            rd_v_reg   <= rd_v_next;
            prod_v_reg <= prod_v_next;
            dcnt_reg   <= dcnt_next;
            dpass_reg  <= dpass_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    rns_pkg::CFG_SIZE:       size_reg   <= cfg_data;
                    rns_pkg::CFG_PART_INDEX: pidx_reg   <= cfg_data[5:0];
                    rns_pkg::CFG_PART_COUNT: pcount_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        begin_reg   <= begin_next;
        end_reg     <= end_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        resid_reg   <= resid_next;
        total_reg   <= total_next;
        sat_reg     <= sat_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a start transaction always makes the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == rns_pkg::OP_START) |=> busy)
        else $error("start transaction did not raise busy");

    // a result only follows a run
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding run");

    // column walk never passes the order in use
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (col_reg <= n_reg))
        else $error("column counter past the system order");

    // the multiply pipeline is drained whenever rounding starts
    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (!rd_v_reg && !prod_v_reg))
        else $error("dot product pipeline not drained before rounding");

endmodule

// File: verif/residual_norm_squared_test.sv
`timescale 1ns / 1ps
// residual_norm_squared_test: self-checking testbench of the residual norm block
// directed table then random load/start sequences under several slice settings
// depends on rns_pkg and residual_norm_squared
module residual_norm_squared_test;

    localparam int MAX_ORDER   = 64;
    localparam int PHASES      = 14;
    localparam int PER_PHASE   = 52;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        bit                  is_write;
        rns_pkg::cfg_index_t reg_index;
        logic [6:0]          reg_data;
        rns_pkg::cmd_t       item;
        bit                  golden_on;
        rns_pkg::result_t    golden;
    } step_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    rns_pkg::cmd_t             cmd;
    logic                      busy;
    logic                      done;
    rns_pkg::result_t          result;
    logic                      cfg_write;
    logic [1:0]                cfg_index;
    logic [rns_pkg::CFG_W-1:0] cfg_data;

    logic signed [31:0] a_mem [MAX_ORDER][MAX_ORDER];
    logic signed [31:0] rhs_mem [MAX_ORDER];
    logic signed [31:0] x_mem [MAX_ORDER];
    bit                 a_known [MAX_ORDER][MAX_ORDER];
    bit                 rhs_known [MAX_ORDER];
    bit                 x_known [MAX_ORDER];
    logic [6:0]         reg_size;
    logic [5:0]         reg_part_index;
    logic [6:0]         reg_part_count;

    rns_pkg::result_t pending_norms [$];
    rns_pkg::result_t want;
    step_t            steps [$];
    int               mismatches;
    int               items_sent;
    int               idle_pct;
    int               quiet_cycles;

    logic [6:0] phase_size [PHASES] = '{1, 4, 8, 64, 3, 16, 127, 2, 64, 5, 100, 64, 7, 0};
    logic [6:0] phase_index [PHASES] = '{0, 0, 1, 63, 2, 3, 62, 0, 1, 7, 63, 0, 6, 5};
    logic [6:0] phase_count [PHASES] = '{1, 1, 2, 64, 3, 4, 64, 0, 8, 0, 127, 32, 7, 3};

    residual_norm_squared #(
        .MAX_ORDER(MAX_ORDER)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void slice_of(output int n, output int lo, output int hi);
        int cnt;
        n = reg_size > MAX_ORDER ? MAX_ORDER : int'(reg_size);
        cnt = reg_part_count == 0 ? 1 : int'(reg_part_count);
        lo = n * int'(reg_part_index) / cnt;
        hi = n * (int'(reg_part_index) + 1) / cnt;
        if (lo > n)
        begin
            lo = n;
        end
        if (hi > n)
        begin
            hi = n;
        end
    endfunction

    function automatic rns_pkg::result_t predict_norm();
        int                 n;
        int                 lo;
        int                 hi;
        logic signed [71:0] dot;
        logic signed [71:0] r;
        logic [63:0]        sq;
        logic [63:0]        total;
        bit                 clip;
        rns_pkg::result_t   res;
        slice_of(n, lo, hi);
        total = '0;
        clip = 1'b0;
        for (int i = lo; i < hi; i++)
        begin
            dot = '0;
            for (int j = 0; j < n; j++)
            begin
                dot = dot + a_mem[i][j] * x_mem[j];
            end
            // round half up to Q16.16, then clamp to 32 bits
            r = ((dot + 72'sd32768) >>> 16) - rhs_mem[i];
            if (r > 72'sd2147483647)
            begin
                r = 72'sd2147483647;
                clip = 1'b1;
            end
            else if (r < -(72'sd2147483648))
            begin
                r = -(72'sd2147483648);
                clip = 1'b1;
            end
            sq = 64'(r * r);
            if (sq > 64'(rns_pkg::SUM_MAX) - total)
            begin
                total = 64'(rns_pkg::SUM_MAX);
                clip = 1'b1;
            end
            else
            begin
                total = total + sq;
            end
        end
        res.residual_sum = total[rns_pkg::SUM_W-1:0];
        res.saturated = clip;
        return res;
    endfunction

    function automatic void absorb(input rns_pkg::cmd_t c);
        case (c.op)
            rns_pkg::OP_LOAD_MATRIX:
            begin
                a_mem[c.row][c.col] = c.value;
                a_known[c.row][c.col] = 1'b1;
            end
            rns_pkg::OP_LOAD_RHS:
            begin
                rhs_mem[c.row] = c.value;
                rhs_known[c.row] = 1'b1;
            end
            rns_pkg::OP_LOAD_SOLUTION:
            begin
                x_mem[c.col] = c.value;
                x_known[c.col] = 1'b1;
            end
            default:
            begin
                pending_norms.push_back(predict_norm());
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2, 3, 4: return 32'($urandom_range(32'h40000)) - 32'h20000;
            5, 6: return 32'($urandom_range(32'h200_0000)) - 32'h100_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic step_t do_cmd(input rns_pkg::op_t op, input int row, input int col,
                                     input logic [31:0] value);
        step_t s;
        s.is_write = 1'b0;
        s.reg_index = rns_pkg::CFG_SIZE;
        s.reg_data = '0;
        s.item.op = op;
        s.item.row = row[5:0];
        s.item.col = col[5:0];
        s.item.value = value;
        s.golden_on = 1'b0;
        s.golden = '0;
        return s;
    endfunction

    function automatic step_t do_write(input rns_pkg::cfg_index_t idx,
                                       input logic [6:0] data);
        step_t s;
        s = do_cmd(rns_pkg::OP_START, 0, 0, '0);
        s.is_write = 1'b1;
        s.reg_index = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic step_t do_check(input logic [rns_pkg::SUM_W-1:0] sum, input bit sat);
        step_t s;
        s = do_cmd(rns_pkg::OP_START, 0, 0, '0);
        s.golden_on = 1'b1;
        s.golden.residual_sum = sum;
        s.golden.saturated = sat;
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // entered and left at a falling edge; start is left high for the next transaction
    task automatic send(input rns_pkg::cmd_t c, input bit golden_on,
                        input rns_pkg::result_t golden);
        idle_pct = items_sent < 550 ? 11 : (items_sent < 1100 ? 86 : 0);
        items_sent++;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (c.op == rns_pkg::OP_START && golden_on)
        begin
            pending_norms.push_back(golden);
        end
        else
        begin
            absorb(c);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input rns_pkg::cfg_index_t idx, input logic [6:0] data);
        start <= 1'b0;
        while (pending_norms.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            rns_pkg::CFG_SIZE: reg_size = data;
            rns_pkg::CFG_PART_INDEX: reg_part_index = data[5:0];
            rns_pkg::CFG_PART_COUNT: reg_part_count = data;
            default: ;
        endcase
    endtask

    // load whatever the slice reads that was never written, then start
    task automatic run_start(input int n, input int lo, input int hi);
        step_t s;
        for (int j = 0; j < n; j++)
        begin
            if (!x_known[j])
            begin
                s = do_cmd(rns_pkg::OP_LOAD_SOLUTION, $urandom_range(63), j, rand_value());
                send(s.item, 1'b0, '0);
            end
        end
        for (int i = lo; i < hi; i++)
        begin
            if (!rhs_known[i])
            begin
                s = do_cmd(rns_pkg::OP_LOAD_RHS, i, $urandom_range(63), rand_value());
                send(s.item, 1'b0, '0);
            end
            for (int j = 0; j < n; j++)
            begin
                if (!a_known[i][j])
                begin
                    s = do_cmd(rns_pkg::OP_LOAD_MATRIX, i, j, rand_value());
                    send(s.item, 1'b0, '0);
                end
            end
        end
        s = do_cmd(rns_pkg::OP_START, $urandom_range(63), $urandom_range(63), $urandom());
        send(s.item, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_norms.size() == 0)
            begin
                flag_mismatch("result with no transaction pending", 64'(result), '0);
            end
            else
            begin
                want = pending_norms.pop_front();
                if (result.residual_sum !== want.residual_sum)
                begin
                    flag_mismatch("residual_sum", 64'(result.residual_sum),
                                  64'(want.residual_sum));
                end
                if (result.saturated !== want.saturated)
                begin
                    flag_mismatch("saturated", 64'(result.saturated), 64'(want.saturated));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int            n;
        int            lo;
        int            hi;
        int            pick;
        bit            focus;
        rns_pkg::cmd_t c;
        step_t         s;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_write = 1'b0;
        cfg_index = rns_pkg::CFG_SIZE;
        cfg_data = '0;
        mismatches = 0;
        items_sent = 0;
        reg_size = 7'd1;
        reg_part_index = '0;
        reg_part_count = 7'd1;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            rhs_mem[i] = '0;
            x_mem[i] = '0;
            rhs_known[i] = 1'b0;
            x_known[i] = 1'b0;
            for (int j = 0; j < MAX_ORDER; j++)
            begin
                a_mem[i][j] = '0;
                a_known[i][j] = 1'b0;
            end
        end

        // directed table
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 0, 0, 32'h7FFF_FFFF));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_SOLUTION, 0, 0, 32'h7FFF_FFFF));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_RHS, 0, 0, 32'h8000_0000));
        steps.push_back(do_check(63'h3FFF_FFFF_0000_0001, 1'b1));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 0, 0, 32'h8000_0000));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF));
        steps.push_back(do_check(63'h4000_0000_0000_0000, 1'b1));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 0, 0, 32'h0000_0001));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_SOLUTION, 0, 0, 32'h0000_8000));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_RHS, 0, 0, 32'h0000_0000));
        steps.push_back(do_check(63'd1, 1'b0));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 0, 0, 32'hFFFF_FFFF));
        steps.push_back(do_check(63'd0, 1'b0));
        steps.push_back(do_write(rns_pkg::CFG_PART_COUNT, 7'd0));
        steps.push_back(do_cmd(rns_pkg::OP_START, 63, 63, 32'hFFFF_FFFF));
        steps.push_back(do_write(rns_pkg::CFG_PART_COUNT, 7'd1));
        steps.push_back(do_write(rns_pkg::CFG_PART_INDEX, 7'd5));
        steps.push_back(do_check(63'd0, 1'b0));
        steps.push_back(do_write(rns_pkg::CFG_SIZE, 7'd0));
        steps.push_back(do_check(63'd0, 1'b0));
        steps.push_back(do_write(rns_pkg::CFG_SIZE, 7'd2));
        steps.push_back(do_write(rns_pkg::CFG_PART_INDEX, 7'd0));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 0, 0, 32'hFFFF_FFFF));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 0, 1, 32'h0000_0000));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 1, 0, 32'hFFFF_FFFF));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_MATRIX, 1, 1, 32'h0000_0000));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_SOLUTION, 0, 0, 32'h0001_0000));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_SOLUTION, 0, 1, 32'h0000_0000));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF));
        steps.push_back(do_cmd(rns_pkg::OP_LOAD_RHS, 1, 0, 32'h7FFF_FFFF));
        steps.push_back(do_check(rns_pkg::SUM_MAX, 1'b1));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (steps[k])
        begin
            s = steps[k];
            if (s.is_write)
            begin
                write_reg(s.reg_index, s.reg_data);
            end
            else
            begin
                send(s.item, s.golden_on, s.golden);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(rns_pkg::CFG_SIZE, phase_size[p]);
            write_reg(rns_pkg::CFG_PART_INDEX, phase_index[p]);
            write_reg(rns_pkg::CFG_PART_COUNT, phase_count[p]);
            slice_of(n, lo, hi);
            repeat (PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 22)
                begin
                    run_start(n, lo, hi);
                end
                else
                begin
                    focus = $urandom_range(3) != 0;
                    c.row = (focus && hi > lo) ? 6'($urandom_range(hi - 1, lo))
                                               : 6'($urandom_range(63));
                    c.col = (focus && n > 0) ? 6'($urandom_range(n - 1, 0))
                                             : 6'($urandom_range(63));
                    c.value = rand_value();
                    if (pick < 62)
                    begin
                        c.op = rns_pkg::OP_LOAD_MATRIX;
                    end
                    else if (pick < 81)
                    begin
                        c.op = rns_pkg::OP_LOAD_RHS;
                    end
                    else
                    begin
                        c.op = rns_pkg::OP_LOAD_SOLUTION;
                    end
                    send(c, 1'b0, '0);
                end
            end
            run_start(n, lo, hi);
        end

        start <= 1'b0;
        while (pending_norms.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: residual_norm_squared.f
rtl/rns_pkg.sv
rtl/rns_ram.sv
rtl/residual_norm_squared.sv
verif/residual_norm_squared_test.sv
